/* src/fsp_pkg.sv */
// Shared types and constants for the format specifier parser.
`default_nettype none
package fsp_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;

  localparam int FLAG_HASH  = 0;
  localparam int FLAG_ZERO  = 1;
  localparam int FLAG_MINUS = 2;
  localparam int FLAG_PLUS  = 3;
  localparam int FLAG_SPACE = 4;

  localparam logic [31:0] SAT_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;

  typedef enum logic [3:0] {
    PH_FLAGS   = 4'd0,
    PH_WDIG    = 4'd1,
    PH_WSTAR   = 4'd2,
    PH_WSDIG   = 4'd3,
    PH_PDIG    = 4'd4,
    PH_PSTAR   = 4'd5,
    PH_PSDIG   = 4'd6,
    PH_AFTER_H = 4'd7,
    PH_AFTER_L = 4'd8,
    PH_CONV    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    LEN_NONE = 3'd0,
    LEN_HH   = 3'd1,
    LEN_H    = 3'd2,
    LEN_L    = 3'd3,
    LEN_LL   = 3'd4,
    LEN_J    = 3'd5,
    LEN_Z    = 3'd6
  } length_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  flags;
    logic [31:0] width_acc;
    logic [31:0] precision_acc;
    logic        dot_seen;
    length_t     length;
  } fsp_state_t;

  typedef struct packed {
    logic [4:0]         flag_bits;
    logic [30:0]        field_width;
    logic signed [31:0] precision_value;
    logic               precision_given;
    logic [2:0]         length_kind;
    logic [7:0]         conversion;
  } fsp_result_t;

  localparam fsp_state_t STATE_RESET = '{
    phase:         PH_FLAGS,
    flags:         5'd0,
    width_acc:     32'd0,
    precision_acc: 32'd0,
    dot_seen:      1'b0,
    length:        LEN_NONE
  };

endpackage
`default_nettype wire

/* src/fsp_if.sv */
// Word channels: format characters in, parsed specifier records out.
`default_nettype none
interface fsp_char_if;
  logic               valid;
  logic               ready;
  logic [7:0]         ch;
  logic signed [31:0] star_value;

  modport source (output valid, output ch, output star_value, input ready);
  modport sink (input valid, input ch, input star_value, output ready);
endinterface

interface fsp_spec_if;
  logic               valid;
  logic               ready;
  logic [4:0]         flag_bits;
  logic [30:0]        field_width;
  logic signed [31:0] precision_value;
  logic               precision_given;
  logic [2:0]         length_kind;
  logic [7:0]         conversion;

  modport source (
    output valid, output flag_bits, output field_width, output precision_value,
    output precision_given, output length_kind, output conversion, input ready
  );
  modport sink (
    input valid, input flag_bits, input field_width, input precision_value,
    input precision_given, input length_kind, input conversion, output ready
  );
endinterface
`default_nettype wire

/* src/fsp_step.sv */
// One parse step: next parser state and the record for a terminating character.
`default_nettype none
module fsp_step (
  input  fsp_pkg::fsp_state_t  st,
  input  logic [7:0]           ch,
  input  logic [31:0]          star_value,
  output fsp_pkg::fsp_state_t  nxt,
  output logic                 emit,
  output fsp_pkg::fsp_result_t res
);
  import fsp_pkg::*;

  function automatic logic [31:0] sat_acc(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
    sat_acc = (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[31:0];
  endfunction

  logic        digit;
  logic [3:0]  dval;
  logic [4:0]  fbit;
  logic        go_wdig;
  logic        dot_path;
  logic        mod_path;
  logic [31:0] wmag;

  assign digit = ch inside {[CH_ZERO:CH_NINE]};
  assign dval  = 4'(ch - CH_ZERO);

  always_comb begin
    case (ch)
      CH_HASH:  fbit = 5'(1) << FLAG_HASH;
      CH_ZERO:  fbit = 5'(1) << FLAG_ZERO;
      CH_MINUS: fbit = 5'(1) << FLAG_MINUS;
      CH_PLUS:  fbit = 5'(1) << FLAG_PLUS;
      CH_SPACE: fbit = 5'(1) << FLAG_SPACE;
      default:  fbit = 5'd0;
    endcase
  end

  always_comb begin
    nxt      = st;
    emit     = 1'b0;
    go_wdig  = 1'b0;
    dot_path = 1'b0;
    mod_path = 1'b0;
    case (st.phase)
      PH_WDIG: begin
        go_wdig = 1'b1;
      end
      PH_WSTAR: begin
        if (digit) begin
          nxt.width_acc = {28'd0, dval};
          nxt.phase     = PH_WSDIG;
        end else begin
          dot_path = 1'b1;
        end
      end
      PH_WSDIG: begin
        if (digit) nxt.width_acc = sat_acc(st.width_acc, dval);
        else dot_path = 1'b1;
      end
      PH_PDIG: begin
        if (digit) begin
          nxt.precision_acc = sat_acc(st.precision_acc, dval);
        end else if (ch == CH_STAR) begin
          nxt.precision_acc = star_value;
          nxt.phase         = PH_PSTAR;
        end else begin
          mod_path = 1'b1;
        end
      end
      PH_PSTAR: begin
        if (digit) begin
          nxt.precision_acc = {28'd0, dval};
          nxt.phase         = PH_PSDIG;
        end else begin
          mod_path = 1'b1;
        end
      end
      PH_PSDIG: begin
        if (digit) nxt.precision_acc = sat_acc(st.precision_acc, dval);
        else mod_path = 1'b1;
      end
      PH_AFTER_H: begin
        if (ch == CH_H) begin
          nxt.length = LEN_HH;
          nxt.phase  = PH_CONV;
        end else begin
          emit = 1'b1;
        end
      end
      PH_AFTER_L: begin
        if (ch == CH_L) begin
          nxt.length = LEN_LL;
          nxt.phase  = PH_CONV;
        end else begin
          emit = 1'b1;
        end
      end
      PH_CONV: begin
        emit = 1'b1;
      end
      default: begin
        if (fbit != 5'd0) begin
          nxt.flags = st.flags | fbit;
          nxt.phase = PH_FLAGS;
        end else begin
          nxt.phase = PH_WDIG;
          go_wdig   = 1'b1;
        end
      end
    endcase

    if (go_wdig) begin
      if (digit) begin
        nxt.width_acc = sat_acc(st.width_acc, dval);
      end else if (ch == CH_STAR) begin
        nxt.width_acc = star_value;
        nxt.phase     = PH_WSTAR;
      end else begin
        dot_path = 1'b1;
      end
    end

    if (dot_path) begin
      if (ch == CH_DOT) begin
        nxt.dot_seen = 1'b1;
        nxt.phase    = PH_PDIG;
      end else begin
        mod_path = 1'b1;
      end
    end

    if (mod_path) begin
      case (ch)
        CH_H: begin
          nxt.length = LEN_H;
          nxt.phase  = PH_AFTER_H;
        end
        CH_L: begin
          nxt.length = LEN_L;
          nxt.phase  = PH_AFTER_L;
        end
        CH_J: begin
          nxt.length = LEN_J;
          nxt.phase  = PH_CONV;
        end
        CH_Z: begin
          nxt.length = LEN_Z;
          nxt.phase  = PH_CONV;
        end
        default: emit = 1'b1;
      endcase
    end

    if (emit) nxt = STATE_RESET;
  end

  assign wmag = (st.width_acc == MOST_NEG) ? SAT_MAX : (32'd0 - st.width_acc);

  always_comb begin
    res.flag_bits       = st.flags;
    res.field_width     = st.width_acc[30:0];
    if (st.width_acc[31]) begin
      res.flag_bits[FLAG_MINUS] = 1'b1;
      res.field_width           = wmag[30:0];
    end
    res.precision_value = st.dot_seen ? st.precision_acc : 32'd0;
    res.precision_given = st.dot_seen;
    res.length_kind     = st.length;
    res.conversion      = ch;
  end

endmodule
`default_nettype wire

/* src/format_spec_parser.sv */
// Top level of the format specifier parser: input stage, parser state, record register.
// A terminating character is staged, then its record is loaded into the record register.
// One character per cycle unless held; the parser state updates once per staged character.
// Back-pressure holds the staged character only when it terminates and the record is held.
// Reset clears the parser to the flags phase and drops staged and pending words.
`default_nettype none
module format_spec_parser (
  input  logic       clk,
  input  logic       rst,
  fsp_char_if.sink   fmt_in,
  fsp_spec_if.source spec_out
);
  import fsp_pkg::*;

  logic        stage_valid;
  logic [7:0]  stage_ch;
  logic [31:0] stage_star;
  fsp_state_t  st;
  fsp_state_t  st_next;
  logic        emit;
  fsp_result_t res_next;
  fsp_result_t res;
  logic        out_valid;
  logic        out_free;
  logic        step_go;

  fsp_step u_step (
    .st         (st),
    .ch         (stage_ch),
    .star_value (stage_star),
    .nxt        (st_next),
    .emit       (emit),
    .res        (res_next)
  );

  assign out_free     = !out_valid || spec_out.ready;
  assign step_go      = stage_valid && (!emit || out_free);
  assign fmt_in.ready = !stage_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      st          <= STATE_RESET;
    end else begin
      if (fmt_in.ready) stage_valid <= fmt_in.valid;
      if (step_go) st <= st_next;
      if (step_go && emit) out_valid <= 1'b1;
      else if (spec_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_in.valid && fmt_in.ready) begin
      stage_ch   <= fmt_in.ch;
      stage_star <= fmt_in.star_value;
    end
    if (step_go && emit) res <= res_next;
  end

  assign spec_out.valid           = out_valid;
  assign spec_out.flag_bits       = res.flag_bits;
  assign spec_out.field_width     = res.field_width;
  assign spec_out.precision_value = res.precision_value;
  assign spec_out.precision_given = res.precision_given;
  assign spec_out.length_kind     = res.length_kind;
  assign spec_out.conversion      = res.conversion;

`ifndef SYNTH
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    step_go && emit |=> st.phase == PH_FLAGS && st.width_acc == 32'd0 && !st.dot_seen)
    else $error("parser state not cleared after record");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !fmt_in.ready |-> stage_valid && out_valid && !spec_out.ready)
    else $error("input stalled without a held record");

  a_no_prec_without_dot: assert property (@(posedge clk) disable iff (rst)
    !st.dot_seen |-> st.precision_acc == 32'd0)
    else $error("precision accumulated without a dot");

  a_record_prec: assert property (@(posedge clk) disable iff (rst)
    spec_out.valid && !spec_out.precision_given |-> spec_out.precision_value == 32'sd0)
    else $error("precision reported without a dot");
`endif

endmodule
`default_nettype wire

/* tb/format_spec_parser_tb.sv */
// Testbench for format_spec_parser: streams format characters in and checks each spec record.
`default_nettype none
module format_spec_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsp_pkg::*;

  logic clk = 1'b0;
  logic rst;

  fsp_char_if char_bus ();
  fsp_spec_if spec_bus ();

  format_spec_parser uut (
    .clk(clk),
    .rst(rst),
    .fmt_in(char_bus),
    .spec_out(spec_bus)
  );

  always #5 clk = ~clk;

  // parser state mirrored by the predictor
  phase_t      parse_phase;
  logic [4:0]  acc_flags;
  logic [31:0] acc_width;
  logic [31:0] acc_prec;
  logic        acc_dot;
  length_t     acc_len;

  fsp_result_t pending_specs[$];
  fsp_result_t want_spec;
  int          send_idle;
  int          recv_idle;
  int          mismatches;
  int          chars_sent;
  int          specs_seen;

  function automatic void clear_spec();
    parse_phase = PH_FLAGS;
    acc_flags   = '0;
    acc_width   = '0;
    acc_prec    = '0;
    acc_dot     = 1'b0;
    acc_len     = LEN_NONE;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [31:0] dec_acc(logic [31:0] acc, logic [7:0] c);
    logic [63:0] v;
    v = {32'd0, acc} * 64'd10 + {56'd0, 8'(c - CH_ZERO)};
    if (v > {32'd0, SAT_MAX}) return SAT_MAX;
    return v[31:0];
  endfunction

  function automatic fsp_result_t close_spec(logic [7:0] c);
    fsp_result_t r;
    logic [4:0]  fl;
    logic [31:0] w;
    fl = acc_flags;
    w = acc_width;
    if (w[31]) begin
      fl[FLAG_MINUS] = 1'b1;
      w = (w == MOST_NEG) ? SAT_MAX : 32'd0 - w;
    end
    r.flag_bits       = fl;
    r.field_width     = w[30:0];
    r.precision_value = acc_dot ? acc_prec : '0;
    r.precision_given = acc_dot;
    r.length_kind     = acc_len;
    r.conversion      = c;
    clear_spec();
    return r;
  endfunction

  function automatic bit length_step(logic [7:0] c, output fsp_result_t r);
    r = '0;
    if (c == CH_H) begin
      acc_len = LEN_H;
      parse_phase = PH_AFTER_H;
      return 1'b0;
    end
    if (c == CH_L) begin
      acc_len = LEN_L;
      parse_phase = PH_AFTER_L;
      return 1'b0;
    end
    if (c == CH_J || c == CH_Z) begin
      acc_len = (c == CH_J) ? LEN_J : LEN_Z;
      parse_phase = PH_CONV;
      return 1'b0;
    end
    r = close_spec(c);
    return 1'b1;
  endfunction

  function automatic bit dot_step(logic [7:0] c, output fsp_result_t r);
    r = '0;
    if (c == CH_DOT) begin
      acc_dot = 1'b1;
      parse_phase = PH_PDIG;
      return 1'b0;
    end
    return length_step(c, r);
  endfunction

  // returns 1 when the character closes a spec, with the record in r
  function automatic bit parse_char(logic [7:0] c, logic [31:0] sv, output fsp_result_t r);
    logic [4:0] fb;
    r = '0;
    fb = '0;
    case (parse_phase)
      PH_WDIG: ;
      PH_WSTAR: begin
        if (is_dec(c)) begin
          acc_width = {24'd0, 8'(c - CH_ZERO)};
          parse_phase = PH_WSDIG;
          return 1'b0;
        end
        return dot_step(c, r);
      end
      PH_WSDIG: begin
        if (is_dec(c)) begin
          acc_width = dec_acc(acc_width, c);
          return 1'b0;
        end
        return dot_step(c, r);
      end
      PH_PDIG: begin
        if (is_dec(c)) begin
          acc_prec = dec_acc(acc_prec, c);
          return 1'b0;
        end
        if (c == CH_STAR) begin
          acc_prec = sv;
          parse_phase = PH_PSTAR;
          return 1'b0;
        end
        return length_step(c, r);
      end
      PH_PSTAR: begin
        if (is_dec(c)) begin
          acc_prec = {24'd0, 8'(c - CH_ZERO)};
          parse_phase = PH_PSDIG;
          return 1'b0;
        end
        return length_step(c, r);
      end
      PH_PSDIG: begin
        if (is_dec(c)) begin
          acc_prec = dec_acc(acc_prec, c);
          return 1'b0;
        end
        return length_step(c, r);
      end
      PH_AFTER_H: begin
        if (c == CH_H) begin
          acc_len = LEN_HH;
          parse_phase = PH_CONV;
          return 1'b0;
        end
        r = close_spec(c);
        return 1'b1;
      end
      PH_AFTER_L: begin
        if (c == CH_L) begin
          acc_len = LEN_LL;
          parse_phase = PH_CONV;
          return 1'b0;
        end
        r = close_spec(c);
        return 1'b1;
      end
      PH_CONV: begin
        r = close_spec(c);
        return 1'b1;
      end
      default: begin
        case (c)
          CH_HASH:  fb[FLAG_HASH] = 1'b1;
          CH_ZERO:  fb[FLAG_ZERO] = 1'b1;
          CH_MINUS: fb[FLAG_MINUS] = 1'b1;
          CH_PLUS:  fb[FLAG_PLUS] = 1'b1;
          CH_SPACE: fb[FLAG_SPACE] = 1'b1;
          default: ;
        endcase
        if (fb != '0) begin
          acc_flags = acc_flags | fb;
          return 1'b0;
        end
        parse_phase = PH_WDIG;
      end
    endcase
    if (is_dec(c)) begin
      acc_width = dec_acc(acc_width, c);
      return 1'b0;
    end
    if (c == CH_STAR) begin
      acc_width = sv;
      parse_phase = PH_WSTAR;
      return 1'b0;
    end
    return dot_step(c, r);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic [31:0] sv);
    fsp_result_t spec;
    while ($urandom_range(99) < send_idle) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid      <= 1'b1;
    char_bus.ch         <= c;
    char_bus.star_value <= sv;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    chars_sent++;
    if (parse_char(c, sv, spec)) pending_specs.push_back(spec);
  endtask

  task automatic send_text(input string s, input logic [31:0] star);
    foreach (s[i]) send_char(s[i], (s[i] == CH_STAR) ? star : 32'($urandom));
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(CH_ZERO + 8'($urandom_range(9)), $urandom);
  endtask

  function automatic logic [31:0] pick_star();
    case ($urandom_range(7))
      0: return MOST_NEG;
      1: return SAT_MAX;
      2: return 32'd0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(100));
      5: return 32'd0 - 32'($urandom_range(100));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(4))
      0: return CH_HASH;
      1: return CH_ZERO;
      2: return CH_MINUS;
      3: return CH_PLUS;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic send_star_digits();
    send_char(CH_STAR, pick_star());
    if ($urandom_range(1)) begin
      send_digits($urandom_range(1, 11));
      if ($urandom_range(3) == 0) send_char(CH_STAR, pick_star());
    end
  endtask

  task automatic send_random_spec();
    string convs;
    int    pick;
    convs = "diouxXfFeEgGaAcspn%";
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom), $urandom);
      return;
    end
    repeat ($urandom_range(0, 3)) send_char(pick_flag(), $urandom);
    case ($urandom_range(5))
      0: ;
      1: send_digits($urandom_range(1, 3));
      2: send_digits($urandom_range(10, 12));
      3: send_star_digits();
      4: begin
        send_digits($urandom_range(1, 2));
        send_char(CH_STAR, pick_star());
      end
      default: send_digits(1);
    endcase
    if ($urandom_range(1)) begin
      send_char(CH_DOT, $urandom);
      case ($urandom_range(4))
        0: ;
        1: send_digits($urandom_range(1, 3));
        2: send_digits($urandom_range(10, 12));
        3: send_star_digits();
        default: begin
          send_digits(1);
          send_char(CH_STAR, pick_star());
        end
      endcase
    end
    case ($urandom_range(9))
      0: send_char(CH_H, $urandom);
      1: begin
        send_char(CH_H, $urandom);
        send_char(CH_H, $urandom);
      end
      2: send_char(CH_L, $urandom);
      3: begin
        send_char(CH_L, $urandom);
        send_char(CH_L, $urandom);
      end
      4: send_char(CH_J, $urandom);
      5: send_char(CH_Z, $urandom);
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < 80) send_char(convs[$urandom_range(convs.len() - 1)], $urandom);
    else if (pick < 92) send_char(8'($urandom), $urandom);
    else send_char(8'h00, $urandom);
  endtask

  task automatic test_flags();
    send_text("#0-+ d", 32'd0);
  endtask

  task automatic test_star_width();
    send_text("*d", MOST_NEG);
    send_text("*7*", 32'hFFFF_FFFF);
  endtask

  task automatic test_precision();
    send_text(".*hhd", MOST_NEG);
  endtask

  task automatic test_length_modifiers();
    send_text("hl", 32'd0);
    send_text("lld", 32'd0);
    send_char(CH_L, $urandom);
    send_char(8'hFF, $urandom);
    send_text("jz", 32'd0);
  endtask

  task automatic test_end_of_string();
    send_char(8'h00, $urandom);
    send_char(CH_Z, $urandom);
    send_char(8'h00, $urandom);
  endtask

  task automatic test_random_stream(input int s_idle, input int r_idle, input int count);
    int target;
    send_idle = s_idle;
    recv_idle = r_idle;
    target = chars_sent + count;
    while (chars_sent < target) send_random_spec();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && spec_bus.valid && spec_bus.ready) begin
      if (pending_specs.size() == 0) begin
        $error("unexpected spec record, conversion %0d", spec_bus.conversion);
        mismatches++;
      end else begin
        want_spec = pending_specs.pop_front();
        specs_seen++;
        check_field("flag_bits", want_spec.flag_bits, spec_bus.flag_bits);
        check_field("field_width", want_spec.field_width, spec_bus.field_width);
        check_field("precision_value", longint'($signed(want_spec.precision_value)),
                    longint'($signed(spec_bus.precision_value)));
        check_field("precision_given", want_spec.precision_given, spec_bus.precision_given);
        check_field("length_kind", want_spec.length_kind, spec_bus.length_kind);
        check_field("conversion", want_spec.conversion, spec_bus.conversion);
      end
    end
    spec_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mismatches = 0;
    chars_sent = 0;
    specs_seen = 0;
    send_idle = 7;
    recv_idle = 76;
    clear_spec();
    rst                 <= 1'b1;
    char_bus.valid      <= 1'b0;
    char_bus.ch         <= '0;
    char_bus.star_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_flags();
    test_star_width();
    test_precision();
    test_length_modifiers();
    test_end_of_string();
    test_random_stream(7, 76, 250);
    test_random_stream(76, 7, 250);
    test_random_stream(0, 0, 250);
    char_bus.valid <= 1'b0;

    while (pending_specs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Streamed %0d format characters and checked %0d spec records", chars_sent,
             specs_seen);
    $display("under three sender/receiver stall profiles, directed cases first.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
